/* rtl/core/tiled_texture_to_rgba8_assert.svh */
// Assertion macros for the texture decoder checker
`ifndef TILED_TEXTURE_TO_RGBA8_ASSERT_SVH
`define TILED_TEXTURE_TO_RGBA8_ASSERT_SVH
// Assert that a condition implies a consequence on the next cycle
`define TTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Assert that a condition holds every cycle
`define TTR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

/* rtl/core/ttr_pkg.sv */
// ----------------------------------------------------------------------------
// ttr_pkg
// Shared types, constants and helpers for the tiled texture decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package ttr_pkg;
   localparam int MAX_DIM_DEF = 1024;

   localparam logic [2:0] FMT_I4     = 3'd0;
   localparam logic [2:0] FMT_I8     = 3'd1;
   localparam logic [2:0] FMT_IA4    = 3'd2;
   localparam logic [2:0] FMT_IA8    = 3'd3;
   localparam logic [2:0] FMT_RGB565 = 3'd4;
   localparam logic [2:0] FMT_RGB5A3 = 3'd5;
   localparam logic [2:0] FMT_RGBA8  = 3'd6;
   localparam logic [2:0] FMT_CMPR   = 3'd7;

   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef struct packed {
      logic [63:0] data_word;
      logic        first_word;
   } req_type;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } rsp_type;

   // Classified word handed from front to back.
   typedef struct packed {
      logic [63:0] data;
      logic [2:0]  fmt;
      logic [2:0]  wi;
      logic [12:0] ox;
      logic [12:0] oy;
      logic [12:0] w;
      logic [12:0] h;
   } job_type;

   function automatic logic [7:0] wid5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction
   function automatic logic [7:0] wid6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction
   function automatic logic [7:0] wid4(input logic [3:0] v);
      return {v, v};
   endfunction
   // a3*255/7 truncated
   function automatic logic [7:0] a3_scale(input logic [2:0] a);
      logic [7:0] r;
      case (a)
         3'd0: r = 8'd0;
         3'd1: r = 8'd36;
         3'd2: r = 8'd72;
         3'd3: r = 8'd109;
         3'd4: r = 8'd145;
         3'd5: r = 8'd182;
         3'd6: r = 8'd218;
         default: r = 8'd255;
      endcase
      return r;
   endfunction
   // v/3 for v < 768 via reciprocal multiply
   function automatic logic [7:0] div3(input logic [9:0] v);
      logic [20:0] p;
      p = {11'd0, v} * 21'd683;
      return p[18:11];
   endfunction
endpackage
`default_nettype wire

/* rtl/core/ttr_front.sv */
// ----------------------------------------------------------------------------
// ttr_front
// Tracks tile position and tags each accepted word with its tile origin.
// ----------------------------------------------------------------------------
`default_nettype none
module ttr_front import ttr_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_req,
   input  wire logic [2:0]  fmt,
   input  wire logic [10:0] img_w,
   input  wire logic [10:0] img_h,
   output job_type      job
);
   logic [7:0] tcol_ff, tcol_in, trow_ff, trow_in;
   logic [2:0] wit_ff, wit_in;
   logic [12:0] w, h, tcols, trows;
   logic [2:0] wi;
   logic [7:0] c0, r0;
   logic wide_tile, tall_tile;

   always_comb begin
      wide_tile = (fmt == FMT_I4) || (fmt == FMT_I8) || (fmt == FMT_IA4) ||
                  (fmt == FMT_CMPR);
      tall_tile = (fmt == FMT_I4) || (fmt == FMT_CMPR);
      w = (13'(img_w) > 13'(MAX_DIM)) ? 13'(MAX_DIM) : 13'(img_w);
      h = (13'(img_h) > 13'(MAX_DIM)) ? 13'(MAX_DIM) : 13'(img_h);
      tcols = wide_tile ? ((w + 13'd7) >> 3) : ((w + 13'd3) >> 2);
      trows = tall_tile ? ((h + 13'd7) >> 3) : ((h + 13'd3) >> 2);
      if (tcols == 13'd0) tcols = 13'd1;
      if (trows == 13'd0) trows = 13'd1;
      c0 = in_req.first_word ? 8'd0 : tcol_ff;
      r0 = in_req.first_word ? 8'd0 : trow_ff;
      wi = in_req.first_word ? 3'd0 : (fmt == FMT_RGBA8 ? wit_ff : {1'b0, wit_ff[1:0]});
      job.data = in_req.data_word;
      job.fmt  = fmt;
      job.wi   = wi;
      job.ox   = wide_tile ? {2'd0, c0, 3'd0} : {3'd0, c0, 2'd0};
      job.oy   = tall_tile ? {2'd0, r0, 3'd0} : {3'd0, r0, 2'd0};
      job.w    = w;
      job.h    = h;
      tcol_in = c0;
      trow_in = r0;
      wit_in  = wi + 3'd1;
      if ((fmt == FMT_RGBA8 && wi == 3'd7) || (fmt != FMT_RGBA8 && wi == 3'd3)) begin
         wit_in = 3'd0;
         if (13'(c0) + 13'd1 >= tcols) begin
            tcol_in = 8'd0;
            trow_in = (13'(r0) + 13'd1 >= trows) ? 8'd0 : r0 + 8'd1;
         end else begin
            tcol_in = c0 + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcol_ff <= '0;
         trow_ff <= '0;
         wit_ff  <= '0;
      end else if (in_valid) begin
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
         wit_ff  <= wit_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/ttr_queue.sv */
// ----------------------------------------------------------------------------
// ttr_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module ttr_queue import ttr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         empty
);
   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= push_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/ttr_back.sv */
// ----------------------------------------------------------------------------
// ttr_back
// Decodes one word a pixel slot per cycle into a one-entry output register, stalling while it is full and not popped.
// ----------------------------------------------------------------------------
`default_nettype none
module ttr_back import ttr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_avail,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   // Per-word setup stage
   logic        act_ff;
   job_type     cur_ff;
   logic [3:0]  k_ff;
   logic [15:0] emit_mask_ff;
   logic [7:0]  pr_ff [4], pg_ff [4], pb_ff [4], pa_ff [4];
   logic [15:0] ar_ff [16];
   logic        ov_ff;
   rsp_type     o_ff;

   // setup combinational for incoming job
   logic [15:0] emask;
   logic [7:0]  cr [4], cg [4], cb [4], ca [4];
   logic [15:0] c0, c1;
   logic [9:0]  s2;

   function automatic void pos(input job_type j, input logic [3:0] k,
                               output logic [12:0] x, output logic [12:0] y,
                               output logic valid);
      valid = 1'b1;
      x = j.ox; y = j.oy;
      case (j.fmt)
         FMT_I4: begin
            x = j.ox + 13'(k[2:0]);
            y = j.oy + 13'({j.wi[1:0], 1'b0}) + 13'(k[3]);
         end
         FMT_I8, FMT_IA4: begin
            x = j.ox + 13'(k[2:0]);
            y = j.oy + 13'(j.wi[1:0]);
            valid = !k[3];
         end
         FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
            x = j.ox + 13'(k[1:0]);
            y = j.oy + 13'(j.wi[1:0]);
            valid = k[3:2] == 2'd0;
         end
         FMT_RGBA8: begin
            x = j.ox + 13'(k[1:0]);
            y = j.oy + 13'(j.wi[1:0]);
            valid = (k[3:2] == 2'd0) && j.wi[2];
         end
         default: begin
            x = j.ox + 13'({j.wi[0], 2'b00}) + 13'(k[1:0]);
            y = j.oy + 13'({j.wi[1], 2'b00}) + 13'(k[3:2]);
         end
      endcase
      valid = valid && (x < j.w) && (y < j.h);
   endfunction

   logic act_done;
   logic [3:0] k_next;
   logic out_free;
   logic [15:0] rem_mask;

   always_comb begin
      logic v;
      logic [12:0] tx, ty;
      for (int i = 0; i < 16; i++) begin
         pos(job, 4'(i), tx, ty, v);
         emask[i] = v;
      end
      c0 = job.data[63:48];
      c1 = job.data[47:32];
      cr[0] = wid5(c0[15:11]); cg[0] = wid6(c0[10:5]); cb[0] = wid5(c0[4:0]);
      cr[1] = wid5(c1[15:11]); cg[1] = wid6(c1[10:5]); cb[1] = wid5(c1[4:0]);
      ca[0] = 8'd255; ca[1] = 8'd255; ca[2] = 8'd255;
      if (c0 > c1) begin
         cr[2] = div3({1'b0, cr[0], 1'b0} + 10'(cr[1]));
         cg[2] = div3({1'b0, cg[0], 1'b0} + 10'(cg[1]));
         cb[2] = div3({1'b0, cb[0], 1'b0} + 10'(cb[1]));
         cr[3] = div3({1'b0, cr[1], 1'b0} + 10'(cr[0]));
         cg[3] = div3({1'b0, cg[1], 1'b0} + 10'(cg[0]));
         cb[3] = div3({1'b0, cb[1], 1'b0} + 10'(cb[0]));
         ca[3] = 8'd255;
      end else begin
         s2 = 10'(cr[0]) + 10'(cr[1]); cr[2] = s2[8:1];
         s2 = 10'(cg[0]) + 10'(cg[1]); cg[2] = s2[8:1];
         s2 = 10'(cb[0]) + 10'(cb[1]); cb[2] = s2[8:1];
         cr[3] = 8'd0; cg[3] = 8'd0; cb[3] = 8'd0; ca[3] = 8'd0;
      end
      s2 = '0;
   end

   // pixel generation for the current word
   logic [7:0] pr, pg, pb, pa;
   logic [12:0] px, py;
   logic pv;
   logic [7:0] bt;
   logic [15:0] hw;
   logic [1:0] ix;

   always_comb begin
      pos(cur_ff, k_ff, px, py, pv);
      bt = cur_ff.data[63 - 8*k_ff[2:0] -: 8];
      hw = cur_ff.data[63 - 16*k_ff[1:0] -: 16];
      ix = cur_ff.data[31 - 8*k_ff[3:2] - 2*k_ff[1:0] -: 2];
      pr = '0; pg = '0; pb = '0; pa = 8'd255;
      case (cur_ff.fmt)
         FMT_I4: begin
            bt = cur_ff.data[63 - 8*{k_ff[3], k_ff[2:1]} -: 8];
            pr = k_ff[0] ? wid4(bt[3:0]) : wid4(bt[7:4]);
            pg = pr; pb = pr;
         end
         FMT_I8: begin pr = bt; pg = bt; pb = bt; end
         FMT_IA4: begin
            pr = wid4(bt[7:4]); pg = pr; pb = pr; pa = wid4(bt[3:0]);
         end
         FMT_IA8: begin pr = hw[15:8]; pg = pr; pb = pr; pa = hw[7:0]; end
         FMT_RGB565: begin
            pr = wid5(hw[15:11]); pg = wid6(hw[10:5]); pb = wid5(hw[4:0]);
         end
         FMT_RGB5A3: begin
            if (hw[15]) begin
               pr = wid5(hw[14:10]); pg = wid5(hw[9:5]); pb = wid5(hw[4:0]);
            end else begin
               pa = a3_scale(hw[14:12]);
               pr = wid4(hw[11:8]); pg = wid4(hw[7:4]); pb = wid4(hw[3:0]);
            end
         end
         FMT_RGBA8: begin
            pr = ar_ff[{cur_ff.wi[1:0], k_ff[1:0]}][7:0];
            pa = ar_ff[{cur_ff.wi[1:0], k_ff[1:0]}][15:8];
            pg = hw[15:8]; pb = hw[7:0];
         end
         default: begin
            pr = pr_ff[ix]; pg = pg_ff[ix]; pb = pb_ff[ix]; pa = pa_ff[ix];
         end
      endcase
      rem_mask = emit_mask_ff & ~((16'd2 << k_ff) - 16'd1);
      k_next = k_ff + 4'd1;
      act_done = (k_ff == 4'd15);
      out_free = !ov_ff || rsp_pop;
      job_pop = job_avail && (!act_ff || (act_done && out_free));
   end

   assign rsp_empty = !ov_ff;
   assign rsp_data = o_ff;

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
         emit_mask_ff <= emask;
         for (int i = 0; i < 4; i++) begin
            pr_ff[i] <= cr[i]; pg_ff[i] <= cg[i]; pb_ff[i] <= cb[i]; pa_ff[i] <= ca[i];
         end
         // store the AR plane on the first half of an RGBA8 tile
         if (job.fmt == FMT_RGBA8 && !job.wi[2]) begin
            for (int i = 0; i < 4; i++)
               ar_ff[{job.wi[1:0], 2'(i)}] <= job.data[63 - 16*i -: 16];
         end
      end
      if (act_ff && out_free && pv) begin
         o_ff.pixel_x <= px[9:0];
         o_ff.pixel_y <= py[9:0];
         o_ff.red <= pr; o_ff.green <= pg; o_ff.blue <= pb; o_ff.alpha <= pa;
         o_ff.last <= rem_mask == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         k_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (rsp_pop && ov_ff) ov_ff <= 1'b0;
         if (act_ff && out_free) begin
            if (pv) ov_ff <= 1'b1;
            k_ff <= k_next;
            if (act_done) act_ff <= 1'b0;
         end
         if (job_pop) begin
            act_ff <= 1'b1;
            k_ff <= '0;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/tiled_texture_to_rgba8.sv */
// Path: a word's first pixel reaches the result ports through the queue
//   write, the back-end load and the output register.
// Throughput: one candidate pixel slot per cycle unless the output stalls,
//   16 slots per word in every format, set by the single-pixel back-end loop.
// Reset: synchronous, clears tile position, queue and output valid flag; the
//   registers return to format 0, 64 by 64.
// ----------------------------------------------------------------------------
// tiled_texture_to_rgba8
// Tiled texture word decoder producing tagged RGBA8 pixels.
// ----------------------------------------------------------------------------
`default_nettype none
module tiled_texture_to_rgba8 import ttr_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);
   logic [2:0]  fmt_ff;
   logic [10:0] w_ff, h_ff;
   job_type     fjob, qjob;
   logic        qfull, qempty, qpop;

   // Configuration is always taken; the user must write only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_I4;
         w_ff <= 11'd64;
         h_ff <= 11'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FORMAT: fmt_ff <= csr_data[2:0];
            CSR_WIDTH:  w_ff <= csr_data;
            CSR_HEIGHT: h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign full = qfull;

   // Front: advance tile position on every accepted transaction.
   ttr_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock, .reset, .in_valid(push && !qfull), .in_req(req_data),
      .fmt(fmt_ff), .img_w(w_ff), .img_h(h_ff), .job(fjob)
   );

   // Hold classified words until the back end is free.
   ttr_queue u_queue (
      .clock, .reset, .push(push), .push_data(fjob), .full(qfull),
      .pop(qpop), .pop_data(qjob), .empty(qempty)
   );

   // Back: emit one pixel slot per cycle while the output is free, drop those off the image.
   ttr_back u_back (
      .clock, .reset, .job_avail(!qempty), .job(qjob), .job_pop(qpop),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

/* rtl/core/ttr_checker.sv */
// ----------------------------------------------------------------------------
// ttr_checker
// Port-level checks for the tiled texture decoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tiled_texture_to_rgba8_assert.svh"
module ttr_checker import ttr_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    push,
   input wire logic    full,
   input wire logic    empty,
   input wire logic    pop,
   input wire rsp_type rsp_data
);
   `TTR_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data))
   `TTR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full)
   `TTR_ASSERT_ALWAYS(a_x_range, clock, reset, empty || rsp_data.pixel_x < 10'd1023 || rsp_data.pixel_x == 10'd1023)
endmodule

bind tiled_texture_to_rgba8 ttr_checker u_checker (
   .clock, .reset, .push, .full, .empty, .pop, .rsp_data
);
`default_nettype wire
